// ===== rtl/paged_slot_allocator_core_assert.svh =====
// Assertion macros used by the paged slot allocator datapath.
`ifndef PAGED_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define PAGED_SLOT_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PSA_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSA_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/psa_pkg.sv =====
// Package: command/status types and result codes for the paged slot allocator.
`default_nettype none

package psa_pkg;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_PAGE  = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

  typedef struct packed {
    logic load_in;
    logic rd_lfp;
    logic rd_scan;
    logic rd_free;
    logic clr_lfv;
    logic take_cnt;
    logic open_start;
    logic fill_step;
    logic open_done;
    logic pop;
    logic pop_latch;
    logic scan_start;
    logic scan_next;
    logic scan_hit;
    logic scan_miss;
    logic free_commit;
    logic set_no_page;
    logic set_bad_free;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic lfp_ok;
    logic cnt_zero;
    logic cnt_full;
    logic pages_full;
    logic fill_last;
    logic cur_empty;
    logic scan_in_range;
    logic free_arg_ok;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/psa_ctrl.sv =====
// Controller FSM: sequences allocate, page open, pop, scan and free steps.
`default_nettype none

module psa_ctrl
  import psa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_ALLOC    = 12'b0000_0000_0010,
    ST_A_CHK    = 12'b0000_0000_0100,
    ST_OPEN     = 12'b0000_0000_1000,
    ST_FILL     = 12'b0000_0001_0000,
    ST_POP      = 12'b0000_0010_0000,
    ST_POP_WAIT = 12'b0000_0100_0000,
    ST_SCAN_RD  = 12'b0000_1000_0000,
    ST_SCAN_CHK = 12'b0001_0000_0000,
    ST_FREE     = 12'b0010_0000_0000,
    ST_F_RD     = 12'b0100_0000_0000,
    ST_DONE     = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = sts.mode ? ST_FREE : ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        if (sts.lfp_ok) begin
          cmd.rd_lfp = 1'b1;
          state_next = ST_A_CHK;
        end else begin
          cmd.clr_lfv = 1'b1;
          state_next  = ST_OPEN;
        end
      end
      ST_A_CHK: begin
        if (sts.cnt_zero) begin
          cmd.clr_lfv = 1'b1;
          state_next  = ST_OPEN;
        end else begin
          cmd.take_cnt = 1'b1;
          state_next   = ST_POP;
        end
      end
      ST_OPEN: begin
        if (sts.pages_full) begin
          cmd.set_no_page = 1'b1;
          state_next      = ST_DONE;
        end else begin
          cmd.open_start = 1'b1;
          state_next     = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) begin
          cmd.open_done = 1'b1;
          state_next    = ST_POP;
        end
      end
      ST_POP: begin
        cmd.pop    = 1'b1;
        state_next = ST_POP_WAIT;
      end
      ST_POP_WAIT: begin
        cmd.pop_latch = 1'b1;
        if (sts.cur_empty) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN_RD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN_RD: begin
        if (sts.scan_in_range) begin
          cmd.rd_scan = 1'b1;
          state_next  = ST_SCAN_CHK;
        end else begin
          cmd.scan_miss = 1'b1;
          state_next    = ST_DONE;
        end
      end
      ST_SCAN_CHK: begin
        if (sts.cnt_zero) begin
          cmd.scan_next = 1'b1;
          state_next    = ST_SCAN_RD;
        end else begin
          cmd.scan_hit = 1'b1;
          state_next   = ST_DONE;
        end
      end
      ST_FREE: begin
        if (sts.free_arg_ok) begin
          cmd.rd_free = 1'b1;
          state_next  = ST_F_RD;
        end else begin
          cmd.set_bad_free = 1'b1;
          state_next       = ST_DONE;
        end
      end
      ST_F_RD: begin
        if (sts.cnt_full) begin
          cmd.set_bad_free = 1'b1;
        end else begin
          cmd.free_commit = 1'b1;
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/psa_dpath.sv =====
// Datapath: free-count and slot-stack memories, page tracking and result register.
`default_nettype none

`include "paged_slot_allocator_core_assert.svh"

module psa_dpath
  import psa_pkg::*;
#(
  parameter int PAGES          = 16,
  parameter int SLOTS_PER_PAGE = 128
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       cmd,
  output sts_t            sts,
  input  wire logic       mode,
  input  wire logic [3:0] page_in,
  input  wire logic [6:0] slot_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [3:0] page_out,
  output logic      [6:0] slot_out,
  output logic      [1:0] status
);

  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int OW    = $clog2(PAGES + 1);
  localparam int SW    = $clog2(SLOTS_PER_PAGE);
  localparam int CW    = $clog2(SLOTS_PER_PAGE + 1);
  localparam int DEPTH = PAGES << SW;

  localparam logic [CW-1:0] CNT_FULL = CW'(SLOTS_PER_PAGE);
  localparam logic [SW-1:0] IDX_TOP  = SW'(SLOTS_PER_PAGE - 1);

  logic [CW-1:0] cnt_mem [PAGES];
  logic [SW-1:0] stack_mem [DEPTH];

  logic [OW-1:0] pages_open;
  logic [PW-1:0] lfp;
  logic          lfv;

  logic [3:0]    in_page;
  logic [6:0]    in_slot;
  logic [PW-1:0] cur_pg;
  logic [CW-1:0] cur_cnt;
  logic [SW-1:0] fill_idx;
  logic [OW-1:0] scan_i;

  logic [PW-1:0] res_page;
  logic [SW-1:0] res_slot;
  logic [1:0]    res_status;

  logic [CW-1:0] cnt_rd;
  logic [SW-1:0] stack_rd;

  logic [PW-1:0]    cnt_raddr;
  logic             cnt_we;
  logic [PW-1:0]    cnt_waddr;
  logic [CW-1:0]    cnt_wdata;
  logic             stk_we;
  logic [PW+SW-1:0] stk_waddr;
  logic [SW-1:0]    stk_wdata;
  logic [CW-1:0]    pop_cnt;
  logic [PW-1:0]    free_pg;

  assign pop_cnt = cur_cnt - 1'b1;
  assign free_pg = PW'(in_page);

  always_comb begin
    if (cmd.rd_scan) begin
      cnt_raddr = scan_i[PW-1:0];
    end else if (cmd.rd_free) begin
      cnt_raddr = free_pg;
    end else begin
      cnt_raddr = lfp;
    end
  end

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = cur_pg;
    cnt_wdata = CNT_FULL;
    if (cmd.open_done) begin
      cnt_we = 1'b1;
    end else if (cmd.pop) begin
      cnt_we    = 1'b1;
      cnt_wdata = pop_cnt;
    end else if (cmd.free_commit) begin
      cnt_we    = 1'b1;
      cnt_waddr = free_pg;
      cnt_wdata = cnt_rd + 1'b1;
    end
  end

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = {cur_pg, fill_idx};
    stk_wdata = IDX_TOP - fill_idx;
    if (cmd.fill_step) begin
      stk_we = 1'b1;
    end else if (cmd.free_commit) begin
      stk_we    = 1'b1;
      stk_waddr = {free_pg, cnt_rd[SW-1:0]};
      stk_wdata = SW'(in_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    stack_rd <= stack_mem[{cur_pg, pop_cnt[SW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_open <= '0;
      lfp        <= '0;
      lfv        <= 1'b0;
    end else begin
      if (cmd.clr_lfv) begin
        lfv <= 1'b0;
      end
      if (cmd.open_done) begin
        pages_open <= pages_open + 1'b1;
        lfp        <= cur_pg;
        lfv        <= 1'b1;
      end
      if (cmd.scan_hit) begin
        lfp <= scan_i[PW-1:0];
      end
      if (cmd.scan_miss) begin
        lfp <= '0;
        lfv <= 1'b0;
      end
      if (cmd.free_commit && (!lfv || free_pg < lfp)) begin
        lfp <= free_pg;
        lfv <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_page    <= page_in;
      in_slot    <= slot_in;
      res_page   <= '0;
      res_slot   <= '0;
      res_status <= STATUS_OK;
    end
    if (cmd.take_cnt) begin
      cur_pg  <= lfp;
      cur_cnt <= cnt_rd;
    end
    if (cmd.open_start) begin
      cur_pg   <= PW'(pages_open);
      fill_idx <= '0;
    end
    if (cmd.fill_step) begin
      fill_idx <= fill_idx + 1'b1;
    end
    if (cmd.open_done) begin
      cur_cnt <= CNT_FULL;
    end
    if (cmd.pop) begin
      cur_cnt <= pop_cnt;
    end
    if (cmd.pop_latch) begin
      res_page <= cur_pg;
      res_slot <= stack_rd;
    end
    if (cmd.scan_start) begin
      scan_i <= OW'(cur_pg) + 1'b1;
    end
    if (cmd.scan_next) begin
      scan_i <= scan_i + 1'b1;
    end
    if (cmd.set_no_page) begin
      res_status <= STATUS_NO_PAGE;
    end
    if (cmd.set_bad_free) begin
      res_status <= STATUS_BAD_FREE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      page_out <= 4'(res_page);
      slot_out <= 7'(res_slot);
      status   <= res_status;
    end
  end

  always_comb begin
    sts.mode          = mode;
    sts.lfp_ok        = lfv && (32'(lfp) < 32'(pages_open));
    sts.cnt_zero      = (cnt_rd == '0);
    sts.cnt_full      = (cnt_rd >= CNT_FULL);
    sts.pages_full    = (32'(pages_open) >= 32'(PAGES));
    sts.fill_last     = (fill_idx == IDX_TOP);
    sts.cur_empty     = (cur_cnt == '0);
    sts.scan_in_range = (scan_i < pages_open);
    sts.free_arg_ok   = (32'(in_page) < 32'(pages_open)) &&
                        (32'(in_slot) < 32'(SLOTS_PER_PAGE));
    sts.out_free      = !out_valid || !out_stall;
  end

  `PSA_ASSERT_IMP(a_lfp_open, clk, rst, lfv, 32'(lfp) < 32'(pages_open), "marker past open pages")
  `PSA_ASSERT_IMP(a_open_max, clk, rst, 1'b1, 32'(pages_open) <= 32'(PAGES), "too many pages open")
  `PSA_ASSERT_IMP(a_fill_pg, clk, rst, cmd.fill_step, 32'(cur_pg) == 32'(pages_open), "fill page")
  `PSA_ASSERT_NXT(a_open_done, clk, rst, cmd.open_done, lfv && cur_cnt == CNT_FULL, "page open")
  `PSA_ASSERT_IMP(a_out_load, clk, rst, cmd.out_load, !out_valid || !out_stall, "result overrun")

endmodule

`default_nettype wire

// ===== rtl/paged_slot_allocator_core.sv =====
// Top level of the paged slot allocator: controller plus datapath.
// Paged slot allocator. Each transfer on the input channel is an allocate (mode 0) or a free
// (mode 1) and yields exactly one result transfer: page/slot and status (0 ok, 1 out of pages,
// 2 bad free). Items are handled one at a time; a finished result sits in an output register
// so the next item is taken while it waits. A free whose page or slot is out of range skips
// the free-count read. An allocate that opens a new page first fills its free stack one entry
// per cycle. When a pop drains its page, later pages are examined for free slots. A stalled
// result register holds the finished item until it is free. The slot stacks are not cleared
// after reset; the block is ready right away.
`default_nettype none

module paged_slot_allocator_core
  import psa_pkg::*;
#(
  parameter int PAGES          = 16,
  parameter int SLOTS_PER_PAGE = 128
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       mode,
  input  wire logic [3:0] page_in,
  input  wire logic [6:0] slot_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [3:0] page_out,
  output logic      [6:0] slot_out,
  output logic      [1:0] status
);

  cmd_t cmd;
  sts_t sts;

  psa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  psa_dpath #(
    .PAGES          (PAGES),
    .SLOTS_PER_PAGE (SLOTS_PER_PAGE)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .mode      (mode),
    .page_in   (page_in),
    .slot_in   (slot_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .page_out  (page_out),
    .slot_out  (slot_out),
    .status    (status)
  );

endmodule

`default_nettype wire
